// File: rtl/fpc_pkg.sv
// Package for the frustum plane extract and box cull block.
// Holds mode codes and memory depths; used by the top-level rtl file and the testbench.
package fpc_pkg;
   localparam logic [1:0] MODE_LOAD   = 2'd0;
   localparam logic [1:0] MODE_DERIVE = 2'd1;
   localparam logic [1:0] MODE_TEST   = 2'd2;
   localparam int unsigned MAT_DEPTH = 16;
   localparam int unsigned PLN_DEPTH = 24;
endpackage

// File: rtl/fpc_divsqrt.sv
// Shared iterative unit: 64-bit integer square root or 49/33-bit restoring divide.
// One result bit per cycle. Depends on nothing but itself.
module fpc_divsqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start_sqrt,
   input  logic        start_div,
   input  logic [65:0] opnd_a,
   input  logic [32:0] opnd_b,
   output logic        done,
   output logic [48:0] result
);
   logic [65:0] rem_ff, rem_in;
   logic [65:0] acc_ff, acc_in;
   logic [48:0] res_ff, res_in;
   logic [32:0] den_ff, den_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, sq_ff, sq_in, done_ff, done_in;
   logic [67:0] trial;
   logic [66:0] dtrial;
   logic [65:0] acc_sh;

   always_comb begin
      rem_in = rem_ff; acc_in = acc_ff; res_in = res_ff; den_in = den_ff;
      cnt_in = cnt_ff; busy_in = busy_ff; sq_in = sq_ff; done_in = 1'b0;
      trial = '0; dtrial = '0; acc_sh = '0;
      if (start_sqrt) begin
         // radicand fits 64 bits: align it to the top so 32 steps cover it
         rem_in = {opnd_a[63:0], 2'b00}; acc_in = '0; res_in = '0; cnt_in = 6'd32;
         busy_in = 1'b1; sq_in = 1'b1;
      end else if (start_div) begin
         rem_in = '0; acc_in = {opnd_a[48:0], 17'd0}; res_in = '0;
         den_in = opnd_b; cnt_in = 6'd49; busy_in = 1'b1; sq_in = 1'b0;
      end else if (busy_ff) begin
         if (sq_ff) begin
            // digit-by-digit: bring two bits in, try (res<<2|1)
            acc_sh = {acc_ff[63:0], rem_ff[65:64]};
            trial = {2'd0, acc_sh} - {17'd0, res_ff, 2'b01};
            rem_in = {rem_ff[63:0], 2'b00};
            if (!trial[67]) begin
               acc_in = trial[65:0]; res_in = {res_ff[47:0], 1'b1};
            end else begin
               acc_in = acc_sh; res_in = {res_ff[47:0], 1'b0};
            end
         end else begin
            dtrial = {rem_ff[65:0], acc_ff[65]} - {34'd0, den_ff};
            acc_in = {acc_ff[64:0], 1'b0};
            if (!dtrial[66]) begin
               rem_in = dtrial[65:0]; res_in = {res_ff[47:0], 1'b1};
            end else begin
               rem_in = {rem_ff[64:0], acc_ff[65]}; res_in = {res_ff[47:0], 1'b0};
            end
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in; acc_ff <= acc_in; res_ff <= res_in; den_ff <= den_in;
      sq_ff <= sq_in; cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
   end

   assign done   = done_ff;
   assign result = res_ff;
endmodule

// File: rtl/frustum_plane_extract_and_box_cull_top.sv
// Top level of the frustum plane extract and box cull block.
// Uses fpc_pkg and fpc_divsqrt.
//
// One item at a time; busy is high while an item runs and rsp_strobe marks its
// single result for one cycle (the receiver cannot stall). The result comes in
// the first cycle after busy drops, and a new item may be accepted in that cycle.
// Load and the unused mode hold busy for 1 cycle. Box test reads each plane
// component in turn through the plane memory's single read port: one 32x32
// multiply per normal component, and the distance plus border shifted up by 16.
// Plane derivation is paced by the bit-serial square root (32 steps) and divider
// (49 steps); a zero-length normal skips its divides.
// After reset a clearing pass zeroes both memories; busy stays high during it.
module frustum_plane_extract_and_box_cull_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_mode,
   input  logic [3:0]         req_elem_index,
   input  logic signed [31:0] req_elem_value,
   input  logic signed [31:0] req_box_min_x,
   input  logic signed [31:0] req_box_min_y,
   input  logic signed [31:0] req_box_min_z,
   input  logic signed [31:0] req_box_max_x,
   input  logic signed [31:0] req_box_max_y,
   input  logic signed [31:0] req_box_max_z,
   output logic               rsp_strobe,
   output logic               rsp_visible,
   output logic [1:0]         rsp_done_mode,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic signed [31:0] csr_data
);
   import fpc_pkg::*;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_RESP, S_DR_RD, S_DR_CAP, S_DR_SQ, S_DR_SQW,
      S_DR_DIV, S_DR_DIVW, S_TB_RD, S_TB_MUL, S_TB_ACC
   } state_type;

   logic signed [31:0] mat_mem [MAT_DEPTH];
   logic signed [31:0] pln_mem [PLN_DEPTH];
   logic [3:0] mat_ra; logic signed [31:0] mat_rd;
   logic [4:0] pln_ra; logic signed [31:0] pln_rd;
   logic mat_we; logic [3:0] mat_wa; logic signed [31:0] mat_wd;
   logic pln_we; logic [4:0] pln_wa; logic signed [31:0] pln_wd;

   state_type state_ff;
   logic [4:0] clr_ff;
   logic [2:0] pl_ff;          // plane 0..5
   logic [2:0] j_ff;           // component / read step
   logic [1:0] ph_ff;          // read phase: r3 or rk
   logic signed [31:0] r3_ff;
   logic [32:0] mag_ff [4];
   logic [3:0]  neg_ff;
   logic [65:0] sq_ff;
   logic [47:0] len_ff;
   logic signed [31:0] bord_ff;
   logic signed [31:0] bmin_ff [3];
   logic signed [31:0] bmax_ff [3];
   logic signed [63:0] prod_ff;
   logic signed [66:0] acc_ff;
   logic vis_ff;
   logic [1:0] mode_ff;
   logic strobe_ff;

   logic ds_sqrt, ds_div, ds_done;
   logic [65:0] ds_a; logic [32:0] ds_b; logic [48:0] ds_res;

   always_ff @(posedge clock) begin
      if (mat_we) mat_mem[mat_wa] <= mat_wd;
      mat_rd <= mat_mem[mat_ra];
      if (pln_we) pln_mem[pln_wa] <= pln_wd;
      pln_rd <= pln_mem[pln_ra];
   end

   fpc_divsqrt u_ds (
      .clock(clock), .reset(reset), .start_sqrt(ds_sqrt), .start_div(ds_div),
      .opnd_a(ds_a), .opnd_b(ds_b), .done(ds_done), .result(ds_res)
   );

   logic signed [33:0] raw;
   logic [33:0] rmag;
   logic [1:0]  row;
   logic [32:0] mg [4];
   logic        halve;
   logic [65:0] sqadd;
   logic [48:0] q;
   logic signed [31:0] qsat;
   logic signed [31:0] nsel;
   logic signed [31:0] bsel;

   always_comb begin
      row   = 2'(pl_ff >> 1);
      raw   = (pl_ff[0] == 1'b0) ? (34'(r3_ff) + 34'(mat_rd)) : (34'(r3_ff) - 34'(mat_rd));
      rmag  = raw[33] ? 34'(-raw) : raw;
      halve = mag_ff[0][31] | mag_ff[0][32] | mag_ff[1][31] | mag_ff[1][32]
            | mag_ff[2][31] | mag_ff[2][32];
      for (int k = 0; k < 4; k++) mg[k] = halve ? (mag_ff[k] >> 1) : mag_ff[k];
      sqadd = 66'(mg[j_ff[1:0]][31:0] * mg[j_ff[1:0]][31:0]);
      q = ds_res;
      if (neg_ff[j_ff[1:0]])
         qsat = (q >= 49'h8000_0000) ? 32'sh8000_0000 : 32'(-$signed({1'b0, q[31:0]}));
      else
         qsat = (q > 49'h7FFF_FFFF) ? 32'sh7FFF_FFFF : 32'(q);
      nsel = pln_rd;
      case (j_ff[1:0])
         2'd0:    bsel = nsel[31] ? bmin_ff[0] : bmax_ff[0];
         2'd1:    bsel = nsel[31] ? bmin_ff[1] : bmax_ff[1];
         default: bsel = nsel[31] ? bmin_ff[2] : bmax_ff[2];
      endcase
   end

   always_comb begin
      mat_we = 1'b0; mat_wa = req_elem_index; mat_wd = req_elem_value;
      pln_we = 1'b0; pln_wa = 5'(pl_ff * 4 + j_ff[1:0]);
      pln_wd = (len_ff == 48'd0) ? 32'sd0 : qsat;
      mat_ra = (ph_ff == 2'd0) ? 4'(3 + 4 * j_ff[1:0]) : 4'(row + 4 * j_ff[1:0]);
      pln_ra = 5'(pl_ff * 4 + j_ff[1:0]);
      ds_sqrt = 1'b0; ds_div = 1'b0;
      ds_a = sq_ff; ds_b = len_ff[32:0];
      if (state_ff == S_CLEAR) begin
         mat_we = clr_ff < 5'd16; mat_wa = clr_ff[3:0]; mat_wd = '0;
         pln_we = 1'b1; pln_wa = clr_ff; pln_wd = '0;
      end else if (state_ff == S_IDLE && start && req_mode == MODE_LOAD) begin
         mat_we = 1'b1;
      end else if (state_ff == S_DR_SQ) begin
         ds_sqrt = 1'b1;
      end else if (state_ff == S_DR_DIV) begin
         // distance magnitude is not bounded by the halving, so keep all 33 bits
         ds_a = {17'd0, mg[j_ff[1:0]], 16'd0}; ds_div = (len_ff != 48'd0);
      end else if (state_ff == S_DR_DIVW && (ds_done || len_ff == 48'd0)) begin
         pln_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR; clr_ff <= '0; bord_ff <= '0; strobe_ff <= 1'b0;
         vis_ff <= 1'b0; mode_ff <= '0;
      end else begin
         strobe_ff <= (state_ff == S_RESP);
         if (csr_valid) bord_ff <= csr_data;
         unique case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + 5'd1;
               if (clr_ff == 5'(PLN_DEPTH - 1)) state_ff <= S_IDLE;
            end
            S_IDLE: if (start) begin
               mode_ff <= req_mode; vis_ff <= (req_mode == MODE_TEST);
               pl_ff <= '0; j_ff <= '0; ph_ff <= '0;
               bmin_ff[0] <= req_box_min_x; bmin_ff[1] <= req_box_min_y;
               bmin_ff[2] <= req_box_min_z; bmax_ff[0] <= req_box_max_x;
               bmax_ff[1] <= req_box_max_y; bmax_ff[2] <= req_box_max_z;
               if (req_mode == MODE_DERIVE) state_ff <= S_DR_RD;
               else if (req_mode == MODE_TEST) begin
                  state_ff <= S_TB_RD; acc_ff <= '0;
               end else state_ff <= S_RESP;
            end
            S_RESP: begin
               state_ff <= S_IDLE;
            end
            S_DR_RD: begin     // issue read of r3 or rk element
               state_ff <= S_DR_CAP;
            end
            S_DR_CAP: begin
               if (ph_ff == 2'd0) begin
                  r3_ff <= mat_rd; ph_ff <= 2'd1; state_ff <= S_DR_RD;
               end else begin
                  mag_ff[j_ff[1:0]] <= rmag[32:0]; neg_ff[j_ff[1:0]] <= raw[33];
                  ph_ff <= 2'd0;
                  if (j_ff == 3'd3) begin
                     j_ff <= '0; sq_ff <= '0; state_ff <= S_DR_SQ;
                  end else begin
                     j_ff <= j_ff + 3'd1; state_ff <= S_DR_RD;
                  end
               end
            end
            S_DR_SQ: begin     // accumulate three squares, then start sqrt
               if (j_ff == 3'd3) begin
                  state_ff <= S_DR_SQW; j_ff <= '0;
               end else begin
                  sq_ff <= sq_ff + sqadd; j_ff <= j_ff + 3'd1;
               end
            end
            S_DR_SQW: if (ds_done) begin
               len_ff <= ds_res[47:0]; state_ff <= S_DR_DIV;
            end
            S_DR_DIV: state_ff <= S_DR_DIVW;
            S_DR_DIVW: if (ds_done || len_ff == 48'd0) begin
               if (j_ff == 3'd3) begin
                  j_ff <= '0;
                  if (pl_ff == 3'd5) state_ff <= S_RESP;
                  else begin
                     pl_ff <= pl_ff + 3'd1; state_ff <= S_DR_RD;
                  end
               end else begin
                  j_ff <= j_ff + 3'd1; state_ff <= S_DR_DIV;
               end
            end
            S_TB_RD: state_ff <= S_TB_MUL;
            S_TB_MUL: begin
               if (j_ff == 3'd3)
                  prod_ff <= (64'(pln_rd) + 64'(bord_ff)) <<< 16;
               else
                  prod_ff <= 64'(nsel) * 64'(bsel);
               state_ff <= S_TB_ACC;
            end
            S_TB_ACC: begin
               if (j_ff == 3'd3) begin
                  if ((acc_ff + 67'(prod_ff)) < 0) vis_ff <= 1'b0;
                  acc_ff <= '0; j_ff <= '0;
                  if (pl_ff == 3'd5) state_ff <= S_RESP;
                  else begin
                     pl_ff <= pl_ff + 3'd1; state_ff <= S_TB_RD;
                  end
               end else begin
                  acc_ff <= acc_ff + 67'(prod_ff); j_ff <= j_ff + 3'd1;
                  state_ff <= S_TB_RD;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy          = (state_ff != S_IDLE);
   assign csr_ready     = 1'b1;
   assign rsp_strobe    = strobe_ff;
   assign rsp_visible   = vis_ff;
   assign rsp_done_mode = mode_ff;
endmodule

// File: verif/tb_top.sv
// Testbench for frustum_plane_extract_and_box_cull_top: directed table, then random items.
// Needs fpc_pkg and the block's rtl; checks each result against a local predictor or, for typed rows, the row's value.
`timescale 1ns / 1ps

module tb_top;
   import fpc_pkg::*;

   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 8_000_000;
   localparam int RAND_ITEMS  = 700;
   localparam int TAIL_ITEMS  = 100;

   typedef struct {
      logic [1:0]         mode;
      logic [3:0]         idx;
      logic signed [31:0] val;
      logic signed [31:0] min_x, min_y, min_z, max_x, max_y, max_z;
   } cull_req_type;

   typedef struct {
      logic       visible;
      logic [1:0] mode;
   } cull_rsp_type;

   typedef struct {
      cull_req_type req;
      bit           typed;
      logic         exp_vis;
   } dir_row_type;

   logic               clock = 0;
   logic               reset = 1;
   logic               start = 0;
   logic               busy;
   logic [1:0]         req_mode = '0;
   logic [3:0]         req_elem_index = '0;
   logic signed [31:0] req_elem_value = '0;
   logic signed [31:0] req_box_min_x = '0, req_box_min_y = '0, req_box_min_z = '0;
   logic signed [31:0] req_box_max_x = '0, req_box_max_y = '0, req_box_max_z = '0;
   logic               rsp_strobe;
   logic               rsp_visible;
   logic [1:0]         rsp_done_mode;
   logic               csr_valid = 0;
   logic               csr_ready;
   logic signed [31:0] csr_data = '0;

   // predictor state
   int           mat_store [16];
   int           plane_store [24];
   int           border;
   cull_rsp_type pending_results [$];
   dir_row_type  dir_rows [$];
   int           err_count, cycles, n_items, n_tests, n_derives, n_visible;

   frustum_plane_extract_and_box_cull_top DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_mode(req_mode), .req_elem_index(req_elem_index),
      .req_elem_value(req_elem_value),
      .req_box_min_x(req_box_min_x), .req_box_min_y(req_box_min_y),
      .req_box_min_z(req_box_min_z), .req_box_max_x(req_box_max_x),
      .req_box_max_y(req_box_max_y), .req_box_max_z(req_box_max_z),
      .rsp_strobe(rsp_strobe), .rsp_visible(rsp_visible),
      .rsp_done_mode(rsp_done_mode),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycles, pending_results.size());
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic report(input string msg);
      err_count++;
      if (err_count <= 40)
         $display("MISMATCH @%0t: %s", $realtime, msg);
   endtask

   always @(posedge clock) begin
      cull_rsp_type exp_r;
      if (!reset && rsp_strobe) begin
         if (rsp_visible === 1'b1)
            n_visible++;
         if (pending_results.size() == 0) begin
            report("result with nothing expected");
         end else begin
            exp_r = pending_results.pop_front();
            if (rsp_done_mode !== exp_r.mode)
               report($sformatf("done_mode %0d, expected %0d", rsp_done_mode, exp_r.mode));
            if (rsp_visible !== exp_r.visible)
               report($sformatf("visible %b, expected %b (mode %0d)",
                                rsp_visible, exp_r.visible, exp_r.mode));
         end
      end
   end

   function automatic longint unsigned int_sqrt(input longint unsigned v);
      longint unsigned res, bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > v)
         bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v   -= res + bitv;
            res  = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   // planes: row3 +/- rows 0..2, normalized by normal length
   function automatic void derive_clip_planes();
      longint          r3, rk, v;
      longint unsigned mag [4];
      bit              neg [4];
      longint unsigned sq, len, q;
      int              row;
      for (int p = 0; p < 6; p++) begin
         row = p >> 1;
         for (int j = 0; j < 4; j++) begin
            r3 = longint'(mat_store[3 + 4 * j]);
            rk = longint'(mat_store[row + 4 * j]);
            v  = (p % 2 == 0) ? r3 + rk : r3 - rk;
            neg[j] = v < 0;
            mag[j] = neg[j] ? longint'(-v) : v;
         end
         if (mag[0] >= 64'h8000_0000 || mag[1] >= 64'h8000_0000 ||
             mag[2] >= 64'h8000_0000)
            for (int j = 0; j < 4; j++)
               mag[j] >>= 1;
         sq  = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
         len = int_sqrt(sq);
         for (int j = 0; j < 4; j++) begin
            if (len == 0) begin
               plane_store[4 * p + j] = 0;
            end else begin
               q = (mag[j] * 64'd65536) / len;
               if (neg[j])
                  plane_store[4 * p + j] = (q >= 64'h8000_0000) ? 32'h8000_0000 : -int'(q);
               else
                  plane_store[4 * p + j] = (q > 64'h7fff_ffff) ? 32'h7fff_ffff : int'(q);
            end
         end
      end
   endfunction

   function automatic bit box_in_frustum(input cull_req_type it);
      longint mn [3], mx [3];
      longint acc, n, plane_dist;
      mn[0] = longint'(it.min_x); mn[1] = longint'(it.min_y); mn[2] = longint'(it.min_z);
      mx[0] = longint'(it.max_x); mx[1] = longint'(it.max_y); mx[2] = longint'(it.max_z);
      for (int p = 0; p < 6; p++) begin
         acc = 0;
         for (int k = 0; k < 3; k++) begin
            n    = longint'(plane_store[4 * p + k]);
            acc += n * ((n >= 0) ? mx[k] : mn[k]);
         end
         plane_dist = longint'(plane_store[4 * p + 3]) + longint'(border);
         acc += plane_dist * 65536;
         if (acc < 0)
            return 0;
      end
      return 1;
   endfunction

   function automatic cull_rsp_type predict_cull_result(input cull_req_type it);
      cull_rsp_type r;
      r.visible = 0;
      r.mode    = it.mode;
      case (it.mode)
         MODE_LOAD:   mat_store[it.idx] = it.val;
         MODE_DERIVE: derive_clip_planes();
         MODE_TEST:   r.visible = box_in_frustum(it);
         default:     ;
      endcase
      return r;
   endfunction

   // called at a falling edge, returns at a falling edge
   task automatic send_item(input cull_req_type it, input bit typed, input logic exp_vis);
      cull_rsp_type r;
      req_mode = it.mode;        req_elem_index = it.idx;   req_elem_value = it.val;
      req_box_min_x = it.min_x;  req_box_min_y = it.min_y;  req_box_min_z = it.min_z;
      req_box_max_x = it.max_x;  req_box_max_y = it.max_y;  req_box_max_z = it.max_z;
      start = 1;
      do @(posedge clock); while (busy);
      r = predict_cull_result(it);
      if (typed)
         r.visible = exp_vis;
      pending_results.push_back(r);
      n_items++;
      if (it.mode == MODE_TEST)   n_tests++;
      if (it.mode == MODE_DERIVE) n_derives++;
      @(negedge clock);
      start = 0;
   endtask

   task automatic write_border(input logic signed [31:0] v);
      while (pending_results.size() != 0)
         @(negedge clock);
      repeat (30) @(negedge clock);
      csr_valid = 1;
      csr_data  = v;
      do @(posedge clock); while (!csr_ready);
      border = v;
      @(negedge clock);
      csr_valid = 0;
      csr_data  = $urandom;
   endtask

   function automatic cull_req_type noise_req(input logic [1:0] mode);
      cull_req_type it;
      it.mode  = mode;
      it.idx   = $urandom;  it.val   = $urandom;
      it.min_x = $urandom;  it.min_y = $urandom;  it.min_z = $urandom;
      it.max_x = $urandom;  it.max_y = $urandom;  it.max_z = $urandom;
      return it;
   endfunction

   function automatic void dir_row(input logic [1:0] mode, input logic [3:0] idx,
                                   input logic signed [31:0] val,
                                   input logic signed [31:0] lo, input logic signed [31:0] hi,
                                   input bit typed, input logic exp_vis);
      dir_row_type d;
      d.req       = noise_req(mode);
      d.req.idx   = idx;
      d.req.val   = val;
      d.req.min_x = lo;  d.req.min_y = lo;  d.req.min_z = lo;
      d.req.max_x = hi;  d.req.max_y = hi;  d.req.max_z = hi;
      d.typed     = typed;
      d.exp_vis   = exp_vis;
      dir_rows.push_back(d);
   endfunction

   function automatic logic signed [31:0] small_q(input int span);
      return $signed($urandom_range(0, 2 * span)) - span;
   endfunction

   function automatic cull_req_type random_req();
      cull_req_type       it;
      int                 sel;
      logic signed [31:0] c, h;
      sel = $urandom_range(0, 99);
      if (sel < 10) begin
         it = noise_req(MODE_LOAD);
         if ($urandom_range(0, 3) != 0)
            it.val = (it.idx % 5 == 0 || it.idx == 15) ?
                     32'sd65536 + small_q(1 << 16) : small_q(1 << 17);
      end else if (sel < 14) begin
         it = noise_req(MODE_DERIVE);
      end else if (sel < 15) begin
         it = noise_req(MODE_UNUSED);
      end else begin
         it = noise_req(MODE_TEST);
         // mostly well-formed boxes near the origin, the rest raw bits
         if ($urandom_range(0, 4) != 0) begin
            c = small_q(1 << 18); h = $urandom_range(0, 1 << 17);
            it.min_x = c - h; it.max_x = c + h;
            c = small_q(1 << 18); h = $urandom_range(0, 1 << 17);
            it.min_y = c - h; it.max_y = c + h;
            c = small_q(1 << 18); h = $urandom_range(0, 1 << 17);
            it.min_z = c - h; it.max_z = c + h;
         end
      end
      return it;
   endfunction

   initial begin
      logic signed [31:0] borders [4];
      int                 done_items;
      foreach (mat_store[i]) mat_store[i] = 0;
      foreach (plane_store[i]) plane_store[i] = 0;
      border = 0;
      repeat (8) @(negedge clock);
      reset = 0;

      // all-zero planes pass everything; unused mode answers invisible
      dir_row(MODE_TEST,   0, 0, 0, 0, 1, 1);
      dir_row(MODE_UNUSED, 0, 0, 0, 0, 1, 0);
      dir_row(MODE_DERIVE, 0, 0, 0, 0, 1, 0);
      dir_row(MODE_TEST,   0, 0, 32'sh8000_0000, 32'sh7fff_ffff, 1, 1);
      // extreme elements: halving of big normals and saturation
      dir_row(MODE_LOAD,   0, 32'sh7fff_ffff, 0, 0, 1, 0);
      dir_row(MODE_LOAD,   3, 32'sh7fff_ffff, 0, 0, 1, 0);
      dir_row(MODE_LOAD,  15, 32'sh7fff_ffff, 0, 0, 1, 0);
      dir_row(MODE_LOAD,  12, 32'sh8000_0000, 0, 0, 1, 0);
      dir_row(MODE_DERIVE, 0, 0, 0, 0, 1, 0);
      dir_row(MODE_TEST,   0, 0, -32'sd65536, 32'sd65536, 0, 0);
      dir_row(MODE_TEST,   0, 0, 32'sh8000_0000, 32'sh7fff_ffff, 0, 0);
      // unit cube frustum
      dir_row(MODE_LOAD,   3, 0, 0, 0, 1, 0);
      dir_row(MODE_LOAD,  12, 0, 0, 0, 1, 0);
      dir_row(MODE_LOAD,  15, 32'sd65536, 0, 0, 1, 0);
      dir_row(MODE_LOAD,   0, 32'sd65536, 0, 0, 1, 0);
      dir_row(MODE_LOAD,   5, 32'sd65536, 0, 0, 1, 0);
      dir_row(MODE_LOAD,  10, 32'sd65536, 0, 0, 1, 0);
      dir_row(MODE_DERIVE, 0, 0, 0, 0, 1, 0);
      dir_row(MODE_TEST,   0, 0, -32'sd32768, 32'sd32768, 0, 0);
      dir_row(MODE_TEST,   0, 0, 32'sd655360, 32'sd720896, 0, 0);
      dir_row(MODE_TEST,   0, 0, 32'sd32768, -32'sd32768, 0, 0);
      dir_row(MODE_TEST,   0, 0, 32'sd65536, 32'sd65536, 0, 0);
      dir_row(MODE_LOAD,   7, 32'sh8000_0000, 0, 0, 1, 0);
      dir_row(MODE_DERIVE, 0, 0, 0, 0, 1, 0);
      dir_row(MODE_TEST,   0, 0, -32'sd65536, 32'sd65536, 0, 0);

      @(negedge clock);
      write_border(0);
      foreach (dir_rows[i])
         send_item(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].exp_vis);

      borders[0] = 32'sd32768;
      borders[1] = 32'sh7fff_ffff;
      borders[2] = 32'sh8000_0000;
      borders[3] = $urandom;
      done_items = 0;
      for (int ph = 0; ph < 4; ph++) begin
         write_border(borders[ph]);
         for (int i = 0; i < RAND_ITEMS / 4; i++) begin
            if (done_items < RAND_ITEMS - TAIL_ITEMS && $urandom_range(0, 7) == 0)
               repeat ($urandom_range(1, 17)) @(negedge clock);
            send_item(random_req(), 0, 0);
            done_items++;
         end
      end
      write_border(0);
      for (int i = 0; i < 20; i++)
         send_item(random_req(), 0, 0);

      while (pending_results.size() != 0)
         @(negedge clock);
      repeat (40) @(negedge clock);

      $display("ran %0d items: %0d box tests (%0d visible), %0d plane derivations",
               n_items, n_tests, n_visible, n_derives);
      $display("border settings: zero, half unit, both extremes, random; %0d cycles",
               cycles);
      if (err_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

// File: filelist.f
rtl/fpc_pkg.sv
rtl/fpc_divsqrt.sv
rtl/frustum_plane_extract_and_box_cull_top.sv
verif/tb_top.sv
